// ===== design/tccs_pkg.sv =====
// Shared types and constants for the text console cursor scroller.
// No dependencies; imported by every module of the block.
`default_nettype none

package tccs_pkg;

  // Grid limits; configured sizes are saturated to these
  localparam int unsigned MAX_COLUMNS = 512;
  localparam int unsigned MAX_ROWS    = 256;

  // Field and register widths
  localparam int unsigned COL_CFG_W  = 10;
  localparam int unsigned ROW_CFG_W  = 9;
  localparam int unsigned COL_W      = 9;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned COLOUR_W   = 24;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [COL_CFG_W-1:0] COLUMNS_MAX = COL_CFG_W'(MAX_COLUMNS);
  localparam logic [ROW_CFG_W-1:0] ROWS_MAX    = ROW_CFG_W'(MAX_ROWS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR = 2'd2;

  // Register reset values
  localparam logic [COL_CFG_W-1:0] COLUMNS_RESET = 10'd80;
  localparam logic [ROW_CFG_W-1:0] ROWS_RESET    = 9'd30;
  localparam logic [COLOUR_W-1:0]  WHITE         = 24'hFFFFFF;

  // Renderer commands
  localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  // Last tab repeat index; a tab expands to TAB_LAST+1 spaces (index runs 0..TAB_LAST)
  localparam logic [1:0] TAB_LAST = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified request, as queued between front and back
  typedef struct packed {
    logic                is_clear;
    logic                is_newline;
    logic                draws;
    logic [1:0]          last_rep;
    logic [CHAR_W-1:0]   glyph;
    logic [COLOUR_W-1:0] fill;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/text_console_cursor_scroller.sv =====
// Top level of the text console cursor scroller: front end, queue, back end.
// Depends on tccs_pkg, tccs_front, tccs_queue and tccs_back.
`default_nettype none

// Requests are accepted into a two-entry queue whenever it has room, so
// input and output stall independently. While its output register is free,
// the back end produces one renderer command per cycle from the queue head:
// a clear or an ordinary character gives one command, a drawn character that
// forces a scroll gives a scroll, then a draw, and a newline or return that
// forces a scroll gives a scroll only. A tab is handled as four spaces, each
// of which may scroll first. Newline or carriage return without a scroll
// produces no command. The back-end sequencer feeds one output register.
module text_console_cursor_scroller
  import tccs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_mode,
  input  wire logic [CHAR_W-1:0]     in_char_code,
  input  wire logic [7:0]            in_fill_red,
  input  wire logic [7:0]            in_fill_green,
  input  wire logic [7:0]            in_fill_blue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CMD_W-1:0]           out_command,
  output logic [CHAR_W-1:0]          out_glyph_code,
  output logic [COL_W-1:0]           out_cell_column,
  output logic [ROW_W-1:0]           out_cell_row,
  output logic [COLOUR_W-1:0]        out_colour,
  output logic                       out_last
);

  logic   q_full;
  logic   q_push;
  entry_t q_push_entry;
  logic   q_pop;
  logic   q_valid;
  entry_t q_head;

  tccs_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .in_fill_red   (in_fill_red),
    .in_fill_green (in_fill_green),
    .in_fill_blue  (in_fill_blue),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_push_entry)
  );

  tccs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  tccs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .q_valid         (q_valid),
    .q_entry         (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_command     (out_command),
    .out_glyph_code  (out_glyph_code),
    .out_cell_column (out_cell_column),
    .out_cell_row    (out_cell_row),
    .out_colour      (out_colour),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== design/tccs_front.sv =====
// Front end: accepts input requests and classifies them into queue entries.
// Depends on tccs_pkg.
`default_nettype none

module tccs_front
  import tccs_pkg::*;
(
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [CHAR_W-1:0] in_char_code,
  input  wire logic [7:0]        in_fill_red,
  input  wire logic [7:0]        in_fill_green,
  input  wire logic [7:0]        in_fill_blue,
  input  wire logic              q_full,
  output logic                   q_push,
  output entry_t                 q_entry
);

  logic is_tab;
  logic is_nl;
  logic is_cr;

  assign is_tab = (in_char_code == CH_TAB);
  assign is_nl  = (in_char_code == CH_NEWLINE);
  assign is_cr  = (in_char_code == CH_RETURN);

  // Take a request whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Tab becomes a run of spaces; newline and return draw nothing
  always_comb begin
    q_entry.is_clear   = in_mode;
    q_entry.is_newline = is_nl;
    q_entry.draws      = !(is_nl || is_cr);
    q_entry.last_rep   = (is_tab && !in_mode) ? TAB_LAST : 2'd0;
    q_entry.glyph      = is_tab ? CH_SPACE : in_char_code;
    q_entry.fill       = {in_fill_red, in_fill_green, in_fill_blue};
  end

endmodule

`default_nettype wire

// ===== design/tccs_queue.sv =====
// Small request queue between the front and back ends.
// Depends on tccs_pkg for the entry type and depth.
`default_nettype none

module tccs_queue
  import tccs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head_entry
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== design/tccs_back.sv =====
// Back end: cursor sequencer, configuration registers and result register.
// Emits one command per cycle while output is free. Depends on tccs_pkg.
`default_nettype none

module tccs_back
  import tccs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // queue head
  input  wire logic                  q_valid,
  input  wire entry_t                q_entry,
  output logic                       q_pop,
  // results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CMD_W-1:0]           out_command,
  output logic [CHAR_W-1:0]          out_glyph_code,
  output logic [COL_W-1:0]           out_cell_column,
  output logic [ROW_W-1:0]           out_cell_row,
  output logic [COLOUR_W-1:0]        out_colour,
  output logic                       out_last
);

  // Configuration registers
  logic [COL_CFG_W-1:0] columns_r;
  logic [ROW_CFG_W-1:0] rows_r;
  logic [COLOUR_W-1:0]  text_colour_r, text_colour_nxt;

  // Cursor state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             pend_r, pend_nxt;
  logic             phase_r, phase_nxt;   // scroll sent, draw still owed
  logic [1:0]       rep_r, rep_nxt;

  // Result register
  logic                out_valid_r;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [CHAR_W-1:0]   glyph_r, glyph_nxt;
  logic [COL_W-1:0]    ocol_r, ocol_nxt;
  logic [ROW_W-1:0]    orow_r, orow_nxt;
  logic [COLOUR_W-1:0] colour_r, colour_nxt;
  logic                last_r, last_nxt;

  // Step datapath
  logic [COL_CFG_W-1:0] cc;
  logic [ROW_CFG_W-1:0] rr;
  logic [ROW_W-1:0]     last_row;
  logic                 col_wrap;
  logic [COL_W-1:0]     cur_col;
  logic [ROW_CFG_W-1:0] cur_row;
  logic                 past_end;
  logic [COL_CFG_W-1:0] inc_col;
  logic                 inc_wrap;
  logic [COL_W-1:0]     step_col;
  logic [ROW_CFG_W:0]   step_row;
  logic                 scroll;
  logic                 final_rep;
  logic                 slot_free;
  logic                 fire;
  logic                 emit;
  logic                 advance;
  logic [COL_W-1:0]     post_col;
  logic                 post_pend;

  // Saturated grid size
  always_comb begin
    if (columns_r == '0) begin
      cc = COL_CFG_W'(1);
    end else if (columns_r > COLUMNS_MAX) begin
      cc = COLUMNS_MAX;
    end else begin
      cc = columns_r;
    end
    if (rows_r == '0) begin
      rr = ROW_CFG_W'(1);
    end else if (rows_r > ROWS_MAX) begin
      rr = ROWS_MAX;
    end else begin
      rr = rows_r;
    end
  end

  assign last_row = ROW_W'(rr - 1'b1);

  // Stale column wraps; stale row counts as past the last cell
  assign col_wrap = !pend_r && ({1'b0, col_r} >= cc);
  assign cur_col  = col_wrap ? '0 : col_r;
  assign cur_row  = {1'b0, row_r} + ROW_CFG_W'(col_wrap);
  assign past_end = pend_r || (cur_row >= rr);

  // Next cursor without scrolling
  assign inc_col  = {1'b0, cur_col} + 1'b1;
  assign inc_wrap = (inc_col >= cc);
  always_comb begin
    if (q_entry.is_newline) begin
      step_col = '0;
      step_row = {1'b0, cur_row} + 1'b1;
    end else begin
      step_col = inc_wrap ? '0 : inc_col[COL_W-1:0];
      step_row = {1'b0, cur_row} + (ROW_CFG_W+1)'(inc_wrap);
    end
  end
  assign scroll = past_end || (step_row >= {1'b0, rr});

  // Cursor after a scroll and the character at the last row start
  always_comb begin
    if (q_entry.is_newline) begin
      post_col  = '0;
      post_pend = 1'b0;
    end else if (cc == COL_CFG_W'(1)) begin
      post_col  = '0;
      post_pend = 1'b1;
    end else begin
      post_col  = COL_W'(1);
      post_pend = 1'b0;
    end
  end

  assign final_rep = (rep_r == q_entry.last_rep);
  assign slot_free = !out_valid_r || out_ready;
  assign fire      = q_valid && slot_free;

  // Sequencer: one result per cycle while the output slot is free
  always_comb begin
    col_nxt         = col_r;
    row_nxt         = row_r;
    pend_nxt        = pend_r;
    phase_nxt       = phase_r;
    rep_nxt         = rep_r;
    text_colour_nxt = text_colour_r;
    emit            = 1'b0;
    advance         = 1'b0;
    q_pop           = 1'b0;
    cmd_nxt         = cmd_r;
    glyph_nxt       = glyph_r;
    ocol_nxt        = ocol_r;
    orow_nxt        = orow_r;
    colour_nxt      = colour_r;
    last_nxt        = last_r;

    if (fire) begin
      if (q_entry.is_clear) begin
        // clear screen, home cursor, restore white text
        emit            = 1'b1;
        q_pop           = 1'b1;
        cmd_nxt         = CMD_CLEAR;
        glyph_nxt       = '0;
        ocol_nxt        = '0;
        orow_nxt        = '0;
        colour_nxt      = q_entry.fill;
        last_nxt        = 1'b1;
        col_nxt         = '0;
        row_nxt         = '0;
        pend_nxt        = 1'b0;
        phase_nxt       = 1'b0;
        rep_nxt         = '0;
        text_colour_nxt = WHITE;
      end else if (phase_r) begin
        // owed draw at the start of the last row
        emit       = 1'b1;
        advance    = 1'b1;
        cmd_nxt    = CMD_DRAW;
        glyph_nxt  = q_entry.glyph;
        ocol_nxt   = '0;
        orow_nxt   = last_row;
        colour_nxt = text_colour_r;
        last_nxt   = final_rep;
        col_nxt    = post_col;
        row_nxt    = last_row;
        pend_nxt   = post_pend;
        phase_nxt  = 1'b0;
      end else if (scroll) begin
        emit       = 1'b1;
        cmd_nxt    = CMD_SCROLL;
        glyph_nxt  = '0;
        ocol_nxt   = '0;
        orow_nxt   = '0;
        colour_nxt = '0;
        last_nxt   = final_rep && !q_entry.draws;
        if (q_entry.draws) begin
          phase_nxt = 1'b1;
        end else begin
          advance  = 1'b1;
          col_nxt  = post_col;
          row_nxt  = last_row;
          pend_nxt = post_pend;
        end
      end else begin
        // plain step; newline and return emit nothing
        emit       = q_entry.draws;
        advance    = 1'b1;
        cmd_nxt    = CMD_DRAW;
        glyph_nxt  = q_entry.glyph;
        ocol_nxt   = cur_col;
        orow_nxt   = cur_row[ROW_W-1:0];
        colour_nxt = text_colour_r;
        last_nxt   = final_rep;
        col_nxt    = step_col;
        row_nxt    = step_row[ROW_W-1:0];
        pend_nxt   = 1'b0;
      end

      if (advance) begin
        if (final_rep) begin
          q_pop   = 1'b1;
          rep_nxt = '0;
        end else begin
          rep_nxt = rep_r + 1'b1;
        end
      end
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r     <= COLUMNS_RESET;
      rows_r        <= ROWS_RESET;
      text_colour_r <= WHITE;
      col_r         <= '0;
      row_r         <= '0;
      pend_r        <= 1'b0;
      phase_r       <= 1'b0;
      rep_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      pend_r        <= pend_nxt;
      phase_r       <= phase_nxt;
      rep_r         <= rep_nxt;
      // a register write takes the text colour over the sequencer value
      if (cfg_we && (cfg_index == REG_TEXT_COLOUR)) begin
        text_colour_r <= cfg_wdata[COLOUR_W-1:0];
      end else begin
        text_colour_r <= text_colour_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMNS: columns_r <= cfg_wdata[COL_CFG_W-1:0];
          REG_ROWS:    rows_r    <= cfg_wdata[ROW_CFG_W-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      cmd_r    <= cmd_nxt;
      glyph_r  <= glyph_nxt;
      ocol_r   <= ocol_nxt;
      orow_r   <= orow_nxt;
      colour_r <= colour_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_command     = cmd_r;
  assign out_glyph_code  = glyph_r;
  assign out_cell_column = ocol_r;
  assign out_cell_row    = orow_r;
  assign out_colour      = colour_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for text_console_cursor_scroller: a directed script, then random
// requests over several grid settings, checked against a cursor and scroll predictor.
// Depends on tccs_pkg and the design sources under design/.

module tb_top;
  import tccs_pkg::*;

  localparam logic MODE_PUT   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;
  // Index past the last register; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam int unsigned HOLD_CYCLES    = 90;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_REQUESTS = 15;
  localparam int unsigned IDLE_PERCENT   = 35;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CHAR_W-1:0]   glyph;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } command_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   mode;
    logic [CHAR_W-1:0]      code;
    logic [COLOUR_W-1:0]    fill;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  value;
    bit                     typed;
    command_t               want;
  } script_row_t;

  // DUT connections
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [CHAR_W-1:0]     in_char_code;
  logic [7:0]            in_fill_red;
  logic [7:0]            in_fill_green;
  logic [7:0]            in_fill_blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [CMD_W-1:0]      out_command;
  logic [CHAR_W-1:0]     out_glyph_code;
  logic [COL_W-1:0]      out_cell_column;
  logic [ROW_W-1:0]      out_cell_row;
  logic [COLOUR_W-1:0]   out_colour;
  logic                  out_last;

  // Predicted console state
  logic [COL_CFG_W-1:0] grid_cols  = COLUMNS_RESET;
  logic [ROW_CFG_W-1:0] grid_rows  = ROWS_RESET;
  logic [COLOUR_W-1:0]  pen_colour = WHITE;
  logic [COL_W-1:0]     cur_col    = '0;
  logic [ROW_W-1:0]     cur_row    = '0;
  bit                   past_end   = 1'b0;

  command_t    step_cmds[$];
  command_t    pending_cmds[$];
  script_row_t script[$];

  bit          steady       = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          need_settle  = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned mismatches   = 0;
  int unsigned requests     = 0;
  int unsigned reg_writes   = 0;
  int unsigned draws        = 0;
  int unsigned scrolls      = 0;
  int unsigned clears       = 0;
  int unsigned idle_cycles  = 0;

  text_console_cursor_scroller uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_char_code    (in_char_code),
    .in_fill_red     (in_fill_red),
    .in_fill_green   (in_fill_green),
    .in_fill_blue    (in_fill_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_command     (out_command),
    .out_glyph_code  (out_glyph_code),
    .out_cell_column (out_cell_column),
    .out_cell_row    (out_cell_row),
    .out_colour      (out_colour),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned saturate_dim(int unsigned v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic command_t make_cmd(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] glyph,
                                        int unsigned col, int unsigned row,
                                        logic [COLOUR_W-1:0] colour);
    command_t c;
    c.command = cmd;
    c.glyph   = glyph;
    c.column  = COL_W'(col);
    c.row     = ROW_W'(row);
    c.colour  = colour;
    c.last    = 1'b0;
    return c;
  endfunction

  // One character cell: scroll first if the next position falls off the grid
  task automatic place_glyph(input logic [CHAR_W-1:0] c);
    int unsigned cc, rr, col, row, nc, nr;
    bit pend;
    cc   = saturate_dim(grid_cols, MAX_COLUMNS);
    rr   = saturate_dim(grid_rows, MAX_ROWS);
    col  = cur_col;
    row  = cur_row;
    nc   = 0;
    nr   = 0;
    pend = past_end;
    // stale cursor left by a smaller grid
    if (!pend && col >= cc) begin
      col = 0;
      row++;
    end
    if (!pend && row >= rr) pend = 1'b1;
    if (!pend) begin
      if (c == CH_NEWLINE) begin
        nc = 0;
        nr = row + 1;
      end else begin
        nc = col + 1;
        nr = row;
        if (nc >= cc) begin
          nc = 0;
          nr++;
        end
      end
    end
    if (pend || nr >= rr) begin
      step_cmds.push_back(make_cmd(CMD_SCROLL, '0, 0, 0, '0));
      row = rr - 1;
      col = 0;
      nr  = rr - 1;
      if (c == CH_NEWLINE) begin
        nc = 0;
      end else begin
        nc = 1;
        if (nc >= cc) begin
          nc = 0;
          nr = rr;
        end
      end
    end
    if (c != CH_NEWLINE && c != CH_RETURN)
      step_cmds.push_back(make_cmd(CMD_DRAW, c, col, row, pen_colour));
    if (nr >= rr) begin
      past_end = 1'b1;
      cur_col  = '0;
      cur_row  = ROW_W'(rr - 1);
    end else begin
      past_end = 1'b0;
      cur_col  = COL_W'(nc);
      cur_row  = ROW_W'(nr);
    end
  endtask

  // Commands caused by one request, left in step_cmds
  task automatic predict_request(input logic mode, input logic [CHAR_W-1:0] code,
                                 input logic [COLOUR_W-1:0] fill);
    command_t tail;
    step_cmds.delete();
    if (mode == MODE_CLEAR) begin
      step_cmds.push_back(make_cmd(CMD_CLEAR, '0, 0, 0, fill));
      cur_col    = '0;
      cur_row    = '0;
      past_end   = 1'b0;
      pen_colour = WHITE;
    end else if (code == CH_TAB) begin
      repeat (4) place_glyph(CH_SPACE);
    end else begin
      place_glyph(code);
    end
    if (step_cmds.size() > 0) begin
      tail = step_cmds.pop_back();
      tail.last = 1'b1;
      step_cmds.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Called and returns at a falling edge; valid stays high for the next request
  task automatic send_request(input logic mode, input logic [CHAR_W-1:0] code,
                              input logic [COLOUR_W-1:0] fill, input bit typed,
                              input command_t want);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_mode       = mode;
    in_char_code  = code;
    in_fill_red   = fill[23:16];
    in_fill_green = fill[15:8];
    in_fill_blue  = fill[7:0];
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(mode, code, fill);
    if (typed) pending_cmds.push_back(want);
    else foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
    requests++;
    need_settle = 1'b1;
    @(negedge clk);
  endtask

  // Drain everything in flight, including requests that make no command
  task automatic settle_block();
    in_valid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    need_settle = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    if (need_settle) settle_block();
    cfg_index = index;
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (index)
      REG_COLUMNS:     grid_cols  = value[COL_CFG_W-1:0];
      REG_ROWS:        grid_rows  = value[ROW_CFG_W-1:0];
      REG_TEXT_COLOUR: pen_colour = value[COLOUR_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------- directed script

  function automatic void add_req(logic mode, logic [CHAR_W-1:0] code,
                                  logic [COLOUR_W-1:0] fill);
    script_row_t r;
    r.kind  = ROW_REQUEST;
    r.mode  = mode;
    r.code  = code;
    r.fill  = fill;
    r.index = '0;
    r.value = '0;
    r.typed = 1'b0;
    r.want  = '0;
    script.push_back(r);
  endfunction

  // Request with its single command written out by hand
  function automatic void add_typed(logic mode, logic [CHAR_W-1:0] code,
                                    logic [COLOUR_W-1:0] fill, logic [CMD_W-1:0] cmd,
                                    logic [CHAR_W-1:0] glyph, int unsigned col,
                                    int unsigned row, logic [COLOUR_W-1:0] colour);
    script_row_t r;
    r.kind  = ROW_REQUEST;
    r.mode  = mode;
    r.code  = code;
    r.fill  = fill;
    r.index = '0;
    r.value = '0;
    r.typed = 1'b1;
    r.want  = make_cmd(cmd, glyph, col, row, colour);
    r.want.last = 1'b1;
    script.push_back(r);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] index,
                                    logic [CFG_DATA_W-1:0] value);
    script_row_t r;
    r.kind  = ROW_WRITE;
    r.mode  = MODE_PUT;
    r.code  = '0;
    r.fill  = '0;
    r.index = index;
    r.value = value;
    r.typed = 1'b0;
    r.want  = '0;
    script.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input command_t want,
                                 input command_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected cmd %0d glyph %02h cell (%0d,%0d) colour %06h last %0b",
               $time, what, want.command, want.glyph, want.column, want.row,
               want.colour, want.last);
      $display("%0t %s: actual   cmd %0d glyph %02h cell (%0d,%0d) colour %06h last %0b",
               $time, what, got.command, got.glyph, got.column, got.row,
               got.colour, got.last);
    end
  endtask

  // Compare each renderer command with the oldest one predicted
  always @(posedge clk) begin
    command_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_command, out_glyph_code, out_cell_column, out_cell_row, out_colour, out_last};
      if (got.command == CMD_DRAW) draws++;
      else if (got.command == CMD_SCROLL) scrolls++;
      else clears++;
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected command", '0, got);
      end else begin
        want = pending_cmds.pop_front();
        if (got.command !== want.command || got.glyph !== want.glyph ||
            got.column !== want.column || got.row !== want.row ||
            got.colour !== want.colour || got.last !== want.last)
          report_mismatch("command mismatch", want, got);
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** text_console_cursor_scroller: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int unsigned phase_cols[PHASES];
    int unsigned phase_rows[PHASES];
    int unsigned pick, cols, rows_n, directed;
    logic                mode;
    logic [CHAR_W-1:0]   code;
    logic [COLOUR_W-1:0] fill;

    phase_cols    = '{4, 1, 7, 2, 512, 3};
    phase_rows    = '{3, 5, 1, 2, 256, 4};
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_mode       = MODE_PUT;
    in_char_code  = '0;
    in_fill_red   = '0;
    in_fill_green = '0;
    in_fill_blue  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset grid is 80 x 30 in white
    add_typed(MODE_PUT, "A", '0, CMD_DRAW, "A", 0, 0, WHITE);
    add_typed(MODE_PUT, 8'h00, '0, CMD_DRAW, 8'h00, 1, 0, WHITE);
    add_typed(MODE_PUT, 8'hFF, 24'hFFFFFF, CMD_DRAW, 8'hFF, 2, 0, WHITE);
    add_req(MODE_PUT, CH_TAB, '0);
    add_req(MODE_PUT, CH_RETURN, '0);
    add_req(MODE_PUT, CH_NEWLINE, '0);
    add_typed(MODE_CLEAR, 8'h00, 24'h000000, CMD_CLEAR, '0, 0, 0, 24'h000000);
    add_typed(MODE_CLEAR, 8'hFF, 24'hFFFFFF, CMD_CLEAR, '0, 0, 0, 24'hFFFFFF);
    // zero sizes act as a single cell; every character scrolls
    add_write(REG_COLUMNS, 24'd0);
    add_write(REG_ROWS, 24'd0);
    add_write(REG_TEXT_COLOUR, 24'h000000);
    add_req(MODE_PUT, "B", '0);
    add_req(MODE_PUT, "C", '0);
    add_req(MODE_PUT, CH_NEWLINE, '0);
    add_req(MODE_PUT, CH_RETURN, '0);
    // oversized grid saturates; the unused index must change nothing
    add_write(REG_COLUMNS, 24'd1023);
    add_write(REG_ROWS, 24'd511);
    add_write(REG_TEXT_COLOUR, 24'h00FF00);
    add_write(REG_NONE, 24'hABCDEF);
    add_req(MODE_PUT, "D", '0);
    add_req(MODE_PUT, CH_TAB, '0);
    // shrink under the cursor: stale position wraps and scrolls
    add_write(REG_COLUMNS, 24'd3);
    add_write(REG_ROWS, 24'd2);
    add_req(MODE_PUT, "E", '0);
    add_req(MODE_PUT, CH_NEWLINE, '0);
    add_req(MODE_PUT, CH_TAB, '0);
    add_req(MODE_PUT, CH_TAB, '0);
    add_typed(MODE_CLEAR, "x", 24'h804020, CMD_CLEAR, '0, 0, 0, 24'h804020);
    add_typed(MODE_PUT, "F", '0, CMD_DRAW, "F", 0, 0, WHITE);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE)
        write_reg(script[i].index, script[i].value);
      else
        send_request(script[i].mode, script[i].code, script[i].fill,
                     script[i].typed, script[i].want);
    end
    directed = requests;

    // Random phases, each on its own grid and colour
    for (int p = 0; p < PHASES; p++) begin
      cols   = phase_cols[p];
      rows_n = phase_rows[p];
      if (p == PHASES - 1) begin
        cols   = $urandom_range(1, 9);
        rows_n = $urandom_range(1, 6);
      end
      write_reg(REG_COLUMNS, CFG_DATA_W'(cols));
      write_reg(REG_ROWS, CFG_DATA_W'(rows_n));
      write_reg(REG_TEXT_COLOUR, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
      steady = (p == 3);
      if (p == 1) hold_off_req = 1'b1;
      repeat (PHASE_REQUESTS) begin
        pick = $urandom_range(0, 99);
        mode = MODE_PUT;
        code = CHAR_W'($urandom_range(0, 255));
        fill = COLOUR_W'($urandom_range(0, 24'hFFFFFF));
        if (pick < 6) mode = MODE_CLEAR;
        else if (pick < 20) code = CH_NEWLINE;
        else if (pick < 32) code = CH_TAB;
        else if (pick < 38) code = CH_RETURN;
        else if (pick < 70) code = CHAR_W'($urandom_range(8'h20, 8'h7E));
        send_request(mode, code, fill, 1'b0, '0);
      end
      steady = 1'b0;
    end

    settle_block();
    $display("Covered %0d requests (%0d directed), %0d register writes, %0d grid settings",
             requests, directed, reg_writes, PHASES + 4);
    $display("Checked %0d draws, %0d scrolls, %0d clears; %0d mismatches",
             draws, scrolls, clears, mismatches);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("** text_console_cursor_scroller: PASSED **");
    end else begin
      $display("** text_console_cursor_scroller: FAILED **");
    end
    $finish;
  end

endmodule
